### hdl/assert_macros.svh
// Assertion shorthands for the heap queue RTL.
// Each macro takes a label, clock, active-low reset, antecedent, consequent and message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BMHQ_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BMHQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/bmhq_pkg.sv
// Shared types and constants for the binary min-heap queue.
// No dependencies; used by every module of the block.
`default_nettype none

package bmhq_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int PRI_W        = 16;
    localparam int DAT_W        = 32;
    localparam int HELD_W       = 7;

    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_POP  = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic [PRI_W-1:0] pri;
        logic [DAT_W-1:0] dat;
    } t_entry;

    typedef struct packed {
        logic [PRI_W-1:0]  pri;
        logic [DAT_W-1:0]  dat;
        t_status           status;
        logic [HELD_W-1:0] held;
        logic              empty;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_POP_LD,
        S_DN_RD,
        S_DN_CMP,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

### hdl/bmhq_mem.sv
// Heap entry storage: one write port, two read ports, registered read data.
// Depends on bmhq_pkg for the entry type.
`default_nettype none

module bmhq_mem
    import bmhq_pkg::*;
#(
    parameter int DEPTH = CAPACITY_DEF,
    parameter int AW    = $clog2(CAPACITY_DEF)
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire t_entry        i_wdata,
    input  wire logic [AW-1:0] i_raddr_a,
    input  wire logic [AW-1:0] i_raddr_b,
    output t_entry             o_rdata_a,
    output t_entry             o_rdata_b
);

    t_entry mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata_a <= mem[i_raddr_a];
        o_rdata_b <= mem[i_raddr_b];
    end

endmodule

`default_nettype wire

### hdl/bmhq_ctrl.sv
// Heap sequencer: push/pop, sift-up and sift-down over the entry memory.
// Depends on bmhq_pkg and drives one bmhq_mem instance.
`default_nettype none

module bmhq_ctrl
    import bmhq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire logic             i_cmd,
    input  wire logic [PRI_W-1:0] i_priority_req,
    input  wire logic [DAT_W-1:0] i_payload,
    output logic                  o_res_valid,
    input  wire logic             i_res_ready,
    output t_result               o_res
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = AW + 1;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [CW-1:0]     r_n, n_n;
    logic [AW-1:0]     r_pos, n_pos;
    t_entry            r_mov, n_mov;
    logic [PRI_W-1:0]  r_rpri, n_rpri;
    logic [DAT_W-1:0]  r_rdat, n_rdat;
    t_status           r_rstat, n_rstat;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr, raddr_a, raddr_b;
    t_entry            mem_wdata, rd_a, rd_b;

    logic [AW-1:0]     parent;
    logic [LW-1:0]     lchild, rchild;
    logic              l_ok, r_ok, take_r;
    t_entry            child;
    logic [AW-1:0]     child_addr;

    bmhq_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    // Index arithmetic for the current hole position.
    assign parent     = AW'((r_pos - AW'(1)) >> 1);
    assign lchild     = {r_pos, 1'b1};
    assign rchild     = lchild + LW'(1);
    assign l_ok       = lchild < LW'(r_n);
    assign r_ok       = rchild < LW'(r_n);
    // Right child only when the left one is strictly greater.
    assign take_r     = r_ok && (rd_a.pri > rd_b.pri);
    assign child      = take_r ? rd_b : rd_a;
    assign child_addr = take_r ? AW'(rchild) : AW'(lchild);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n     <= n_n;
        r_pos   <= n_pos;
        r_mov   <= n_mov;
        r_rpri  <= n_rpri;
        r_rdat  <= n_rdat;
        r_rstat <= n_rstat;
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_n         = r_n;
        n_pos       = r_pos;
        n_mov       = r_mov;
        n_rpri      = r_rpri;
        n_rdat      = r_rdat;
        n_rstat     = r_rstat;
        mem_we      = 1'b0;
        mem_waddr   = r_pos;
        mem_wdata   = r_mov;
        raddr_a     = '0;
        raddr_b     = '0;
        o_res_valid = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_rpri  = '0;
                    n_rdat  = '0;
                    n_rstat = ST_OK;
                    if (t_cmd'(i_cmd) == CMD_PUSH) begin
                        if (r_cnt == CW'(CAPACITY)) begin
                            n_rstat = ST_FULL;
                            n_state = S_DONE;
                        end else begin
                            n_mov   = '{pri: i_priority_req, dat: i_payload};
                            n_pos   = AW'(r_cnt);
                            n_cnt   = r_cnt + CW'(1);
                            n_state = S_UP_RD;
                        end
                    end else begin
                        if (r_cnt == '0) begin
                            n_rstat = ST_EMPTY;
                            n_state = S_DONE;
                        end else begin
                            // fetch root and last entry together
                            n_cnt   = r_cnt - CW'(1);
                            n_n     = r_cnt - CW'(1);
                            raddr_a = '0;
                            raddr_b = AW'(r_cnt - CW'(1));
                            n_state = S_POP_LD;
                        end
                    end
                end
            end
            S_UP_RD: begin
                if (r_pos == '0) begin
                    mem_we  = 1'b1;
                    n_state = S_DONE;
                end else begin
                    raddr_a = parent;
                    n_state = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                mem_we = 1'b1;
                if (r_mov.pri < rd_a.pri) begin
                    mem_wdata = rd_a;   // parent moves down into the hole
                    n_pos     = parent;
                    n_state   = S_UP_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_POP_LD: begin
                n_rpri  = rd_a.pri;
                n_rdat  = rd_a.dat;
                n_mov   = rd_b;
                n_pos   = '0;
                n_state = S_DN_RD;
            end
            S_DN_RD: begin
                if (!l_ok) begin
                    mem_we  = 1'b1;
                    n_state = S_DONE;
                end else begin
                    raddr_a = AW'(lchild);
                    raddr_b = AW'(rchild);
                    n_state = S_DN_CMP;
                end
            end
            S_DN_CMP: begin
                mem_we = 1'b1;
                if (child.pri < r_mov.pri) begin
                    mem_wdata = child;  // child moves up into the hole
                    n_pos     = child_addr;
                    n_state   = S_DN_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_res.pri    = r_rpri;
    assign o_res.dat    = r_rdat;
    assign o_res.status = r_rstat;
    assign o_res.held   = HELD_W'(r_cnt);
    assign o_res.empty  = (r_cnt == '0);

endmodule

`default_nettype wire

### hdl/binary_min_heap_queue_unit.sv
// Binary min-heap priority queue: top level with the result output register.
// Depends on bmhq_pkg, bmhq_ctrl (with bmhq_mem) and assert_macros.svh.
//
// Usage:
//  - Input channel (i_in_valid / o_in_stall): one transaction carries i_cmd
//    (push or pop), i_priority_req and i_payload. One item is in work at a time;
//    o_in_stall is high from acceptance until the sequencer is back in idle.
//  - Output channel (o_out_valid / i_out_stall): exactly one result transaction
//    per accepted item: popped priority/payload (zero on push or rejected pop),
//    status (ok, full, empty), entry count after the operation and empty flag.
//  - Each level moved costs one memory read and one compare/write-back: a push
//    reads the parent (S_UP_RD) and compares (S_UP_CMP); a pop first loads the
//    root and last entry (S_POP_LD), then reads both children (S_DN_RD) and
//    compares (S_DN_CMP); the root or a leaf ends a walk without a compare.
//    At most log2(CAPACITY) levels; a reject goes straight to the done state.
//  - The output register lets the next item be accepted and worked while a
//    finished result waits; if that next result is ready while the register is
//    still stalled, the sequencer holds in its done state and input stalls.
//  - Reset (synchronous, active low) empties the queue and drops any pending
//    result; entry memory contents are not cleared and need no clearing pass.
`default_nettype none
`include "assert_macros.svh"

module binary_min_heap_queue_unit
    import bmhq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic              i_cmd,
    input  wire logic [PRI_W-1:0]  i_priority_req,
    input  wire logic [DAT_W-1:0]  i_payload,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [PRI_W-1:0]       o_out_priority,
    output logic [DAT_W-1:0]       o_out_payload,
    output logic [1:0]             o_status,
    output logic [HELD_W-1:0]      o_entries_held,
    output logic                   o_is_empty
);

    logic    res_valid;
    logic    out_free;
    t_result res;
    logic    r_ov;
    t_result r_out;

    // Output register may load when empty or being drained this cycle.
    assign out_free = !r_ov || !i_out_stall;

    bmhq_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_cmd          (i_cmd),
        .i_priority_req (i_priority_req),
        .i_payload      (i_payload),
        .o_res_valid    (res_valid),
        .i_res_ready    (out_free),
        .o_res          (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (res_valid && out_free) begin
            r_ov <= 1'b1;
        end else if (!i_out_stall) begin
            r_ov <= 1'b0;
        end
    end

    // Payload only; held while stalled since out_free is low then.
    always_ff @(posedge i_clk) begin
        if (res_valid && out_free) begin
            r_out <= res;
        end
    end

    assign o_out_valid    = r_ov;
    assign o_out_priority = r_out.pri;
    assign o_out_payload  = r_out.dat;
    assign o_status       = r_out.status;
    assign o_entries_held = r_out.held;
    assign o_is_empty     = r_out.empty;

    // One item at a time: an accepted transaction stalls the input next cycle.
    `BMHQ_ASSERT_NEXT(a_single_item, i_clk, i_rst_n, i_in_valid && !o_in_stall,
        o_in_stall, "input accepted while item in work")
    // A push is rejected only with the queue at capacity.
    `BMHQ_ASSERT_NOW(a_full_count, i_clk, i_rst_n, o_out_valid && (o_status == ST_FULL),
        o_entries_held == HELD_W'(CAPACITY), "full status with count below capacity")
    // A pop is rejected only with the queue empty.
    `BMHQ_ASSERT_NOW(a_empty_flag, i_clk, i_rst_n, o_out_valid && (o_status == ST_EMPTY),
        o_is_empty, "empty status with entries held")
    // Rejected operations return no entry.
    `BMHQ_ASSERT_NOW(a_reject_zero, i_clk, i_rst_n, o_out_valid && (o_status != ST_OK),
        (o_out_priority == '0) && (o_out_payload == '0), "rejected result carries data")

endmodule

`default_nettype wire
